// ===== sv/cla_pkg.sv =====
// Shared types and codes for the console line assembler.
// No dependencies; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
package cla_pkg;

	localparam int BUF_DEPTH_DEF = 32;
	localparam int CHAR_W        = 7;
	localparam int LEN_W         = 6;
	localparam int KIND_W        = 2;

	localparam logic [LEN_W-1:0] LIMIT_RST = 6'd32;

	localparam logic [CHAR_W-1:0] CH_BS  = 7'h08;
	localparam logic [CHAR_W-1:0] CH_DEL = 7'h7F;
	localparam logic [CHAR_W-1:0] CH_CR  = 7'h0D;
	localparam logic [CHAR_W-1:0] CH_LF  = 7'h0A;

	localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

	// class of the character waiting at the input
	localparam logic [2:0] CLS_SWALLOW = 3'd0;
	localparam logic [2:0] CLS_LF      = 3'd1;
	localparam logic [2:0] CLS_CR      = 3'd2;
	localparam logic [2:0] CLS_BS      = 3'd3;
	localparam logic [2:0] CLS_STORE   = 3'd4;
	localparam logic [2:0] CLS_FULL    = 3'd5;

	// source of the output byte
	localparam logic [1:0] SRC_CHAR = 2'd0;
	localparam logic [1:0] SRC_LF   = 2'd1;
	localparam logic [1:0] SRC_LINE = 2'd2;
	localparam logic [1:0] SRC_END  = 2'd3;

	typedef struct packed {
		logic              out_load;
		logic [KIND_W-1:0] out_kind;
		logic [1:0]        out_src;
		logic              out_last;
		logic              store;
		logic              back;
		logic              cr_set;
		logic              cr_clr;
		logic              line_start;
		logic              line_short;
		logic              idx_inc;
	} cmd_t;

	typedef struct packed {
		logic [2:0] cls;
		logic       out_free;
		logic       idx_last;
		logic       fill_one;
	} stat_t;

endpackage

// ===== sv/cla_if.sv =====
// Request channels of the console line assembler: received characters in,
// result items out. Depends on cla_pkg for field widths.
`timescale 1ns / 1ps
interface cla_in_if;
	logic                         valid;
	logic                         ready;
	logic [cla_pkg::CHAR_W-1:0]   rx_char;

	modport source (output valid, output rx_char, input ready);
	modport sink   (input valid, input rx_char, output ready);
endinterface

interface cla_out_if;
	logic                         valid;
	logic                         ready;
	logic [cla_pkg::KIND_W-1:0]   out_kind;
	logic [cla_pkg::CHAR_W-1:0]   out_byte;
	logic [cla_pkg::LEN_W-1:0]    line_length;
	logic                         run_last;

	modport source (output valid, output out_kind, output out_byte, output line_length,
		output run_last, input ready);
	modport sink   (input valid, input out_kind, input out_byte, input line_length,
		input run_last, output ready);
endinterface

// ===== sv/console_line_assembler_core.sv =====
// Console line assembler: echo and backspace-edited line buffer.
// The first result of a request is registered and appears in the cycle after it is taken.
// Throughput: one request per cycle while the output is free, if it does not end a line;
// a line end brings the LF echo after CR, line bytes one per cycle, then the end item.
// Reset clears fill index, CR flag and sequencer; line limit returns to 32;
// the line store is not cleared.
`timescale 1ns / 1ps
module console_line_assembler_core #(
	parameter int BUF_DEPTH = cla_pkg::BUF_DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	cla_in_if.sink                    rx_ch,
	cla_out_if.source                 res,
	input  logic                      cfg_we,
	input  logic [cla_pkg::LEN_W-1:0] cfg_wdata
);

	cla_pkg::cmd_t  cmd;
	cla_pkg::stat_t st;

	cla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx_ch.valid),
		.rx_ready (rx_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	cla_dp #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_char   (rx_ch.rx_char),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.st        (st),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.res_kind  (res.out_kind),
		.res_byte  (res.out_byte),
		.res_len   (res.line_length),
		.res_last  (res.run_last)
	);

endmodule

// ===== sv/cla_ctrl.sv =====
// Sequencer of the console line assembler: echo, extra LF, line bytes, end item.
// Depends on cla_pkg for the command and status structs.
`timescale 1ns / 1ps
module cla_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rx_valid,
	output logic           rx_ready,
	input  cla_pkg::stat_t st,
	output cla_pkg::cmd_t  cmd
);

	localparam logic [1:0] S_IDLE    = 2'd0;
	localparam logic [1:0] S_ECHO_LF = 2'd1;
	localparam logic [1:0] S_BYTES   = 2'd2;
	localparam logic [1:0] S_END     = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign rx_ready = (state_q == S_IDLE) && st.out_free;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (rx_valid && rx_ready) begin
					cmd.out_kind = cla_pkg::KIND_ECHO;
					cmd.out_src  = cla_pkg::SRC_CHAR;
					case (st.cls)
						cla_pkg::CLS_SWALLOW: begin
							cmd.cr_clr = 1'b1;
						end
						cla_pkg::CLS_LF: begin
							cmd.out_load   = 1'b1;
							cmd.out_src    = cla_pkg::SRC_LF;
							cmd.line_start = 1'b1;
							state_d        = S_BYTES;
						end
						cla_pkg::CLS_CR: begin
							cmd.out_load   = 1'b1;
							cmd.line_start = 1'b1;
							cmd.cr_set     = 1'b1;
							state_d        = S_ECHO_LF;
						end
						cla_pkg::CLS_BS: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							cmd.back     = 1'b1;
						end
						cla_pkg::CLS_STORE: begin
							cmd.out_load = 1'b1;
							cmd.out_last = 1'b1;
							cmd.store    = 1'b1;
							cmd.cr_clr   = 1'b1;
						end
						cla_pkg::CLS_FULL: begin
							// line goes out without its last stored character
							cmd.out_load   = 1'b1;
							cmd.line_start = 1'b1;
							cmd.line_short = 1'b1;
							cmd.cr_clr     = 1'b1;
							state_d        = st.fill_one ? S_END : S_BYTES;
						end
						default: begin
							cmd.out_load = 1'b0;
						end
					endcase
				end
			end
			S_ECHO_LF: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = cla_pkg::KIND_ECHO;
					cmd.out_src  = cla_pkg::SRC_LF;
					state_d      = S_BYTES;
				end
			end
			S_BYTES: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = cla_pkg::KIND_BYTE;
					cmd.out_src  = cla_pkg::SRC_LINE;
					cmd.idx_inc  = 1'b1;
					if (st.idx_last) begin
						state_d = S_END;
					end
				end
			end
			S_END: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = cla_pkg::KIND_END;
					cmd.out_src  = cla_pkg::SRC_END;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== sv/cla_dp.sv =====
// Datapath of the console line assembler: line store, fill index, limit
// register, read-out counter and output register. Depends on cla_pkg.
`timescale 1ns / 1ps
module cla_dp #(
	parameter int BUF_DEPTH = cla_pkg::BUF_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [cla_pkg::CHAR_W-1:0]    rx_char,
	input  logic                          cfg_we,
	input  logic [cla_pkg::LEN_W-1:0]     cfg_wdata,
	input  cla_pkg::cmd_t                 cmd,
	output cla_pkg::stat_t                st,
	output logic                          res_valid,
	input  logic                          res_ready,
	output logic [cla_pkg::KIND_W-1:0]    res_kind,
	output logic [cla_pkg::CHAR_W-1:0]    res_byte,
	output logic [cla_pkg::LEN_W-1:0]     res_len,
	output logic                          res_last
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int FW = $clog2(BUF_DEPTH + 1);
	localparam logic [cla_pkg::LEN_W-1:0] DEPTH_L = cla_pkg::LEN_W'(BUF_DEPTH);
	localparam logic [FW-1:0] DEPTH_F = FW'(BUF_DEPTH);

	logic [cla_pkg::CHAR_W-1:0] mem [BUF_DEPTH];
	logic [cla_pkg::CHAR_W-1:0] rd_data_q;
	logic [FW-1:0]              fill_q;
	logic [FW-1:0]              len_q;
	logic [FW-1:0]              idx_q;
	logic [FW-1:0]              idx_d;
	logic [AW-1:0]              rd_addr;
	logic                       after_cr_q;
	logic                       lf_sub_q;
	logic [cla_pkg::LEN_W-1:0]  limit_q;
	logic [cla_pkg::LEN_W-1:0]  limit_eff;
	logic [cla_pkg::LEN_W-1:0]  fill_l;
	logic [cla_pkg::CHAR_W-1:0] byte_d;
	logic                       is_ord;
	logic [2:0]                 cls;

	// limit of zero acts as one, above the store depth as the depth
	always_comb begin
		limit_eff = limit_q;
		if (limit_q == '0) begin
			limit_eff = cla_pkg::LEN_W'(1);
		end else if (limit_q > DEPTH_L) begin
			limit_eff = DEPTH_L;
		end
	end

	assign fill_l = cla_pkg::LEN_W'(fill_q);
	assign is_ord = !(rx_char inside {cla_pkg::CH_LF, cla_pkg::CH_CR, cla_pkg::CH_BS,
		cla_pkg::CH_DEL});

	always_comb begin
		if (rx_char == cla_pkg::CH_LF) begin
			cls = after_cr_q ? cla_pkg::CLS_SWALLOW : cla_pkg::CLS_LF;
		end else if (rx_char == cla_pkg::CH_CR) begin
			cls = cla_pkg::CLS_CR;
		end else if (!is_ord) begin
			cls = cla_pkg::CLS_BS;
		end else if (fill_l < limit_eff) begin
			cls = cla_pkg::CLS_STORE;
		end else begin
			cls = cla_pkg::CLS_FULL;
		end
	end

	assign st.cls      = cls;
	assign st.out_free = !res_valid || res_ready;
	assign st.idx_last = (idx_q + FW'(1)) == len_q;
	assign st.fill_one = fill_q == FW'(1);

	// read-out counter runs one address ahead so data is ready when a byte is taken
	always_comb begin
		if (cmd.line_start) begin
			idx_d = '0;
		end else if (cmd.idx_inc) begin
			idx_d = idx_q + FW'(1);
		end else begin
			idx_d = idx_q;
		end
		rd_addr = (idx_d >= DEPTH_F) ? '0 : idx_d[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[fill_q[AW-1:0]] <= rx_char;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			after_cr_q <= 1'b0;
			limit_q    <= cla_pkg::LIMIT_RST;
			idx_q      <= '0;
			len_q      <= '0;
			lf_sub_q   <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.cr_set) begin
				after_cr_q <= 1'b1;
			end else if (cmd.cr_clr) begin
				after_cr_q <= 1'b0;
			end
			if (cmd.line_start) begin
				fill_q <= '0;
				if (cmd.line_short) begin
					len_q    <= fill_q - FW'(1);
					lf_sub_q <= 1'b0;
				end else if (fill_q == '0) begin
					// empty line goes out as a single LF
					len_q    <= FW'(1);
					lf_sub_q <= 1'b1;
				end else begin
					len_q    <= fill_q;
					lf_sub_q <= 1'b0;
				end
			end else if (cmd.store) begin
				fill_q <= fill_q + FW'(1);
			end else if (cmd.back && (fill_q != '0)) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

	always_comb begin
		case (cmd.out_src)
			cla_pkg::SRC_CHAR: byte_d = rx_char;
			cla_pkg::SRC_LF:   byte_d = cla_pkg::CH_LF;
			cla_pkg::SRC_LINE: byte_d = lf_sub_q ? cla_pkg::CH_LF : rd_data_q;
			default:           byte_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_kind <= cmd.out_kind;
			res_byte <= byte_d;
			res_len  <= (cmd.out_src == cla_pkg::SRC_END)
				? cla_pkg::LEN_W'(len_q) : '0;
			res_last <= cmd.out_last;
		end
	end

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for console_line_assembler_core: echo, backspace editing and line read-out.
// Depends on cla_pkg and the request interfaces in cla_if; the predictor runs on every accepted
// request and queues the items it expects, which the output monitor checks in order.
`timescale 1ns / 1ps
module tb;

	localparam int BUF_DEPTH       = cla_pkg::BUF_DEPTH_DEF;
	localparam int HOLD_CYCLES     = 300;
	localparam int WATCHDOG_CYCLES = 3000;
	localparam int SETTLE_CYCLES   = 8;

	typedef struct {
		logic [cla_pkg::KIND_W-1:0] kind;
		logic [cla_pkg::CHAR_W-1:0] data;
		logic [cla_pkg::LEN_W-1:0]  len;
		logic                       last;
	} line_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [cla_pkg::LEN_W-1:0] cfg_wdata;

	cla_in_if  rx_if ();
	cla_out_if res_if ();

	console_line_assembler_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_ch     (rx_if),
		.res       (res_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [cla_pkg::CHAR_W-1:0] line_buf [BUF_DEPTH];
	logic [cla_pkg::LEN_W-1:0]  line_fill = '0;
	logic                       cr_seen   = 1'b0;
	logic [cla_pkg::LEN_W-1:0]  limit_reg = cla_pkg::LIMIT_RST;
	line_item_t                 pending_items [$];

	int errors      = 0;
	bit src_idle_on = 1'b1;
	bit snk_idle_on = 1'b1;
	bit hold_req    = 1'b0;

	function automatic int eff_limit();
		if (limit_reg < 1)
			return 1;
		if (limit_reg > BUF_DEPTH)
			return BUF_DEPTH;
		return int'(limit_reg);
	endfunction

	task automatic push_item(input logic [cla_pkg::KIND_W-1:0] kind,
			input logic [cla_pkg::CHAR_W-1:0] data, input logic [cla_pkg::LEN_W-1:0] len,
			input logic last);
		line_item_t it;
		it.kind = kind;
		it.data = data;
		it.len  = len;
		it.last = last;
		pending_items.push_back(it);
	endtask

	task automatic emit_line(input int len);
		for (int i = 0; i < len; i++)
			push_item(cla_pkg::KIND_BYTE, line_buf[i], '0, 1'b0);
		push_item(cla_pkg::KIND_END, '0, cla_pkg::LEN_W'(len), 1'b1);
	endtask

	// an empty line goes out as a single LF byte
	task automatic close_line();
		if (line_fill == 0) begin
			line_buf[0] = cla_pkg::CH_LF;
			line_fill = cla_pkg::LEN_W'(1);
		end
		emit_line(int'(line_fill));
		line_fill = '0;
	endtask

	task automatic assemble_char(input logic [cla_pkg::CHAR_W-1:0] c);
		if (c == cla_pkg::CH_LF) begin
			if (cr_seen) begin
				cr_seen = 1'b0;
			end else begin
				push_item(cla_pkg::KIND_ECHO, cla_pkg::CH_LF, '0, 1'b0);
				close_line();
			end
		end else if (c == cla_pkg::CH_BS || c == cla_pkg::CH_DEL) begin
			push_item(cla_pkg::KIND_ECHO, c, '0, 1'b1);
			if (line_fill != 0)
				line_fill = line_fill - 1'b1;
		end else if (c == cla_pkg::CH_CR) begin
			push_item(cla_pkg::KIND_ECHO, c, '0, 1'b0);
			push_item(cla_pkg::KIND_ECHO, cla_pkg::CH_LF, '0, 1'b0);
			close_line();
			cr_seen = 1'b1;
		end else begin
			cr_seen = 1'b0;
			if (line_fill < eff_limit()) begin
				push_item(cla_pkg::KIND_ECHO, c, '0, 1'b1);
				line_buf[line_fill] = c;
				line_fill = line_fill + 1'b1;
			end else begin
				// full: last stored character is cut off
				push_item(cla_pkg::KIND_ECHO, c, '0, 1'b0);
				emit_line(int'(line_fill) - 1);
				line_fill = '0;
			end
		end
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_char(input logic [cla_pkg::CHAR_W-1:0] c);
		int gap;
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 17);
			rx_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.rx_char = c;
		rx_if.valid   = 1'b1;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		assemble_char(c);
		@(negedge clk);
	endtask

	// a swallowed LF yields nothing, so wait SETTLE_CYCLES past the last result
	task automatic settle();
		rx_if.valid = 1'b0;
		while (pending_items.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [cla_pkg::LEN_W-1:0] v);
		cfg_wdata = v;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we    = 1'b0;
		limit_reg = v;
	endtask

	task automatic test_editing();
		send_char("a");
		send_char("b");
		send_char(cla_pkg::CH_BS);
		send_char("c");
		send_char(cla_pkg::CH_DEL);
		send_char(cla_pkg::CH_CR);
		send_char(cla_pkg::CH_LF);   // swallowed
		send_char(cla_pkg::CH_LF);   // lone LF on empty line
		send_char(cla_pkg::CH_BS);   // at zero
		send_char(cla_pkg::CH_CR);   // empty line
		send_char(cla_pkg::CH_BS);   // leaves the CR flag alone
		send_char(cla_pkg::CH_LF);   // still swallowed
		send_char(7'h00);
		send_char(7'h7E);
		send_char(cla_pkg::CH_LF);
		settle();
	endtask

	task automatic test_line_limits();
		write_limit(6'd1);
		send_char("p");
		send_char("q");     // full, empty line emitted
		settle();
		write_limit(6'd0);  // behaves as 1
		send_char("r");
		send_char("s");
		settle();
		write_limit(6'd32);
		send_char("u");
		send_char("v");
		send_char("w");
		settle();
		write_limit(6'd2);  // lowered mid-line
		send_char("z");
		settle();
		write_limit(6'd63);
		send_char("k");
		send_char(cla_pkg::CH_CR);
		settle();
	endtask

	// sink holds off while lines keep coming, so the block backs up to its input
	task automatic test_back_pressure();
		write_limit(6'd32);
		hold_req = 1'b1;
		for (int n = 0; n < 4; n++) begin
			for (int k = 0; k < 5; k++)
				send_char(cla_pkg::CHAR_W'($urandom_range(32, 126)));
			send_char(cla_pkg::CH_CR);
		end
		settle();
	endtask

	task automatic test_random_traffic(input logic [cla_pkg::LEN_W-1:0] lim_val,
			input int n_items, input bit idle_on);
		int sent;
		int len;
		int lim;
		int pick;
		logic [cla_pkg::CHAR_W-1:0] c;
		settle();
		write_limit(lim_val);
		src_idle_on = idle_on;
		snk_idle_on = idle_on;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				lim  = eff_limit();
				pick = $urandom_range(0, 5);
				if (pick == 0)
					len = lim + $urandom_range(0, 2);
				else if (pick == 1)
					len = $urandom_range(0, lim);
				else
					len = $urandom_range(0, (lim < 6) ? lim : 6);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 7) == 0)
						c = $urandom_range(0, 1) ? cla_pkg::CH_BS : cla_pkg::CH_DEL;
					else
						c = cla_pkg::CHAR_W'($urandom_range(32, 126));
					send_char(c);
					sent++;
				end
				if ($urandom_range(0, 2) == 0) begin
					send_char(cla_pkg::CH_LF);
					sent++;
				end else begin
					send_char(cla_pkg::CH_CR);
					sent++;
					if ($urandom_range(0, 2) != 0) begin
						send_char(cla_pkg::CH_LF);
						sent++;
					end
				end
			end else begin
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++) begin
					send_char(cla_pkg::CHAR_W'($urandom_range(0, 127)));
					sent++;
				end
			end
		end
	endtask

	// sink side: random idle bursts, plus the long hold-off on request
	initial begin
		int idle_left;
		int hold_left;
		idle_left = 0;
		hold_left = 0;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready = 1'b0;
			end else if (idle_left > 0) begin
				idle_left--;
				res_if.ready = 1'b0;
			end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
				idle_left = $urandom_range(1, 17) - 1;
				res_if.ready = 1'b0;
			end else begin
				res_if.ready = 1'b1;
			end
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		line_item_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_items.size() == 0) begin
				$error("unexpected result: kind %h byte %h length %h", res_if.out_kind,
					res_if.out_byte, res_if.line_length);
				errors++;
			end else begin
				want = pending_items.pop_front();
				check_field("out_kind", 8'(want.kind), 8'(res_if.out_kind));
				check_field("out_byte", 8'(want.data), 8'(res_if.out_byte));
				check_field("line_length", 8'(want.len), 8'(res_if.line_length));
				check_field("run_last", 8'(want.last), 8'(res_if.run_last));
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		rx_if.valid   = 1'b0;
		rx_if.rx_char = '0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_editing();
		test_line_limits();
		test_back_pressure();
		test_random_traffic(6'd32, 42, 1'b1);
		test_random_traffic(6'd63, 42, 1'b1);
		test_random_traffic(6'd1, 42, 1'b1);
		test_random_traffic(6'd0, 42, 1'b1);
		test_random_traffic(6'd33, 42, 1'b1);
		test_random_traffic(cla_pkg::LEN_W'($urandom_range(2, 31)), 42, 1'b1);
		test_random_traffic(6'd32, 42, 1'b0);
		settle();

		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
